FILE: hw/rtl/acfr_pkg.sv
// shared types, character codes and hex decode functions for the ascii can frame receiver
// no dependencies
`default_nettype none

package acfr_pkg;

	localparam int CharW    = 8;
	localparam int OpcodeW  = 8;
	localparam int CountW   = 3;
	localparam int PayloadW = 56;
	localparam int CharCntW = 4;
	localparam int DigitW   = 5;

	localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CharW-1:0] CHAR_S     = 8'h53;
	localparam logic [CharW-1:0] CHAR_X     = 8'h58;

	// header characters skipped after the type letter, plus the one separator
	localparam logic [CharCntW-1:0] SKIP_STD = 4'd5;
	localparam logic [CharCntW-1:0] SKIP_EXT = 4'd9;

	// first byte index that falls outside the payload; bytes 0 to 6 land inside it
	localparam logic [CountW-1:0] LAST_IDX = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_SKIP,
		PH_OPC_HI,
		PH_OPC_LO,
		PH_DAT_HI,
		PH_DAT_LO,
		PH_END
	} phase_t;

	typedef struct packed {
		logic [OpcodeW-1:0]  opcode;
		logic [CountW-1:0]   data_count;
		logic [PayloadW-1:0] payload;
		logic                is_extended;
	} frame_t;

	// bit 4 flags a valid digit, bits 3..0 carry its value
	function automatic logic [DigitW-1:0] hex_digit(input logic [CharW-1:0] c);
		logic [DigitW-1:0] d;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d = {1'b1, c[3:0] + 4'd9};
		end
		return d;
	endfunction

	function automatic logic [7:0] hex_pair(input logic [DigitW-1:0] hi,
		input logic [CharW-1:0] lo_char);
		logic [DigitW-1:0] lo;
		logic [7:0]        b;
		lo = hex_digit(lo_char);
		if (!hi[4]) begin
			b = 8'h00;
		end else if (!lo[4]) begin
			b = {4'h0, hi[3:0]};
		end else begin
			b = {hi[3:0], lo[3:0]};
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/acfr_parser.sv
// per-character frame parser: phase machine, hex decode and payload assembly
// depends on acfr_pkg
`default_nettype none

module acfr_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      ch_valid,
	input  wire logic [acfr_pkg::CharW-1:0] ch,
	input  wire logic                      out_free,
	output logic                           ch_take,
	output logic                           res_load,
	output acfr_pkg::frame_t               res
);

	acfr_pkg::phase_t                        phase_q, phase_d;
	logic [acfr_pkg::CharCntW-1:0]           char_count_q, char_count_d;
	logic                                    ext_q, ext_d;
	logic [acfr_pkg::DigitW-1:0]             high_digit_q, high_digit_d;
	logic [acfr_pkg::OpcodeW-1:0]            opcode_q, opcode_d;
	logic [acfr_pkg::CountW-1:0]             bytes_left_q, bytes_left_d;
	logic [acfr_pkg::PayloadW-1:0]           payload_q, payload_d;
	logic [7:0]                              pair;
	logic [acfr_pkg::CountW-1:0]             k;

	// the final character can only be taken when the result slot is free
	assign ch_take  = ch_valid && (phase_q != acfr_pkg::PH_END || out_free);
	assign res_load = ch_take && phase_q == acfr_pkg::PH_END;

	assign res.opcode      = opcode_q;
	assign res.data_count  = opcode_q[7:5];
	assign res.payload     = payload_q;
	assign res.is_extended = ext_q;

	assign pair = acfr_pkg::hex_pair(high_digit_q, ch);
	assign k    = char_count_q[acfr_pkg::CountW-1:0];

	always_comb begin
		phase_d      = phase_q;
		char_count_d = char_count_q;
		ext_d        = ext_q;
		high_digit_d = high_digit_q;
		opcode_d     = opcode_q;
		bytes_left_d = bytes_left_q;
		payload_d    = payload_q;
		unique case (phase_q)
			acfr_pkg::PH_IDLE: begin
				if (ch == acfr_pkg::CHAR_COLON) phase_d = acfr_pkg::PH_TYPE;
			end
			acfr_pkg::PH_TYPE: begin
				if (ch == acfr_pkg::CHAR_S) begin
					ext_d        = 1'b0;
					char_count_d = acfr_pkg::SKIP_STD;
					phase_d      = acfr_pkg::PH_SKIP;
				end else if (ch == acfr_pkg::CHAR_X) begin
					ext_d        = 1'b1;
					char_count_d = acfr_pkg::SKIP_EXT;
					phase_d      = acfr_pkg::PH_SKIP;
				end else begin
					phase_d = acfr_pkg::PH_IDLE;
				end
			end
			acfr_pkg::PH_SKIP: begin
				char_count_d = char_count_q - 1'b1;
				if (char_count_q == 4'd1) phase_d = acfr_pkg::PH_OPC_HI;
			end
			acfr_pkg::PH_OPC_HI: begin
				high_digit_d = acfr_pkg::hex_digit(ch);
				phase_d      = acfr_pkg::PH_OPC_LO;
			end
			acfr_pkg::PH_DAT_HI: begin
				high_digit_d = acfr_pkg::hex_digit(ch);
				phase_d      = acfr_pkg::PH_DAT_LO;
			end
			acfr_pkg::PH_OPC_LO: begin
				opcode_d     = pair;
				bytes_left_d = pair[7:5];
				payload_d    = '0;
				char_count_d = '0;
				phase_d      = (pair[7:5] == '0) ? acfr_pkg::PH_END : acfr_pkg::PH_DAT_HI;
			end
			acfr_pkg::PH_DAT_LO: begin
				if (k != acfr_pkg::LAST_IDX) payload_d[8*k +: 8] = payload_q[8*k +: 8] | pair;
				char_count_d = char_count_q + 1'b1;
				bytes_left_d = bytes_left_q - 1'b1;
				phase_d      = (bytes_left_q == 3'd1) ? acfr_pkg::PH_END : acfr_pkg::PH_DAT_HI;
			end
			acfr_pkg::PH_END: begin
				phase_d = acfr_pkg::PH_IDLE;
			end
			default: phase_d = acfr_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acfr_pkg::PH_IDLE;
		end else if (ch_take) begin
			phase_q <= phase_d;
		end
	end

	// every field below is written before the phase machine reads it
	always_ff @(posedge clk) begin
		if (ch_take) begin
			char_count_q <= char_count_d;
			ext_q        <= ext_d;
			high_digit_q <= high_digit_d;
			opcode_q     <= opcode_d;
			bytes_left_q <= bytes_left_d;
			payload_q    <= payload_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/acfr_out_reg.sv
// result register holding one decoded frame word until the consumer takes it
// depends on acfr_pkg
`default_nettype none

module acfr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire acfr_pkg::frame_t  din,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output acfr_pkg::frame_t       dout
);

	logic             valid_q;
	acfr_pkg::frame_t data_q;

	// slot frees in the same cycle the waiting word is taken
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign dout      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= din;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ascii_can_frame_receiver_core.sv
// ascii can frame receiver: serial characters in, one decoded frame word out per frame
// usage:
//   input channel in_valid/in_ready carries rx_char, one ascii character per word,
//   taken at any edge where both are high; one character per cycle is sustained while in_ready stays high.
//   output channel out_valid/out_ready carries opcode, data_count, payload and
//   is_extended for each completed frame (":S hhhh N oo dd.. ;" or the X form).
//   a character is captured in an input register and the phase machine consumes it from
//   there; the frame word is loaded into the result register at the edge at which the
//   parser consumes the final character, and out_valid rises after that edge.
//   throughput is one character per cycle unless a waiting frame word stalls the parser.
//   if out_ready stays low while a frame word waits, the parser still consumes every
//   character up to the next frame's final one; that character then holds in the input
//   register and in_ready drops until the waiting word is taken.
//   reset (arst_n low) empties both registers and returns the parser to waiting for ':'.
// depends on acfr_pkg, acfr_parser, acfr_out_reg
`default_nettype none

module ascii_can_frame_receiver_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [acfr_pkg::CharW-1:0]    rx_char,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [acfr_pkg::OpcodeW-1:0]       opcode,
	output logic [acfr_pkg::CountW-1:0]        data_count,
	output logic [acfr_pkg::PayloadW-1:0]      payload,
	output logic                               is_extended
);

	logic                       valid_s1;
	logic [acfr_pkg::CharW-1:0] char_s1;
	logic                       take;
	logic                       res_load;
	logic                       out_free;
	acfr_pkg::frame_t           res;
	acfr_pkg::frame_t           dout;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) char_s1 <= rx_char;
	end

	acfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (valid_s1),
		.ch       (char_s1),
		.out_free (out_free),
		.ch_take  (take),
		.res_load (res_load),
		.res      (res)
	);

	acfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.din       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (dout)
	);

	assign opcode      = dout.opcode;
	assign data_count  = dout.data_count;
	assign payload     = dout.payload;
	assign is_extended = dout.is_extended;

endmodule

`default_nettype wire
